// ===== rtl/magnetometer_heading_macros.svh =====
// ---------------------------------------------------------------------------
// Magnetometer heading assertion macros
// Shared concurrent assertion forms for the heading block.
// ---------------------------------------------------------------------------
`ifndef MAGNETOMETER_HEADING_MACROS_SVH
`define MAGNETOMETER_HEADING_MACROS_SVH

// Checked only out of reset
`define MH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included
`define MH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/mhead_pkg.sv =====
// ---------------------------------------------------------------------------
// Magnetometer heading package
// Shared widths, types, register codes and the arctangent table.
// ---------------------------------------------------------------------------
package mhead_pkg;

  localparam int ANGLE_STAGES = 16;  // 8..24
  localparam int TABLE_LEN    = 24;
  localparam int STAGE_W      = $clog2(TABLE_LEN);
  localparam int XW           = 19;  // rotation datapath, holds |v| * 1.65 * sqrt2
  localparam int ZW           = 26;  // angle, degrees Q16, holds +/-(180 + 100)

  localparam logic signed [ZW-1:0] Z_DEG90  = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] Z_DEG180 = ZW'(180 * 65536);

  typedef enum logic [2:0] {
    CFG_OFFSET_X = 3'd0,
    CFG_OFFSET_Y = 3'd1,
    CFG_OFFSET_Z = 3'd2,
    CFG_SCALE_X  = 3'd3,
    CFG_SCALE_Y  = 3'd4,
    CFG_SCALE_Z  = 3'd5,
    CFG_MOUNT    = 3'd6,
    CFG_DECL     = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MNT_ROT0       = 3'd0,
    MNT_ROT90      = 3'd1,
    MNT_ROT180     = 3'd2,
    MNT_ROT270     = 3'd3,
    MNT_FLIP_ROT0  = 3'd4,
    MNT_FLIP_ROT90 = 3'd5,
    MNT_FLIP_ROT180 = 3'd6,
    MNT_FLIP_ROT270 = 3'd7
  } mount_e;

  typedef struct packed {
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_z;
    logic [15:0]        scale_x;
    logic [15:0]        scale_y;
    logic [15:0]        scale_z;
    logic [2:0]         mount;
    logic signed [15:0] decl;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic signed [15:0] fz;
  } field_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 hold;  // angle already final, cells pass it on
    field_t               f;
  } cordic_t;

  // round(atan(2^-i) in degrees * 65536)
  function automatic logic signed [ZW-1:0] atan_entry(input logic [STAGE_W-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = ZW'(2949120);
      5'd1:    v = ZW'(1740967);
      5'd2:    v = ZW'(919879);
      5'd3:    v = ZW'(466945);
      5'd4:    v = ZW'(234379);
      5'd5:    v = ZW'(117304);
      5'd6:    v = ZW'(58666);
      5'd7:    v = ZW'(29335);
      5'd8:    v = ZW'(14668);
      5'd9:    v = ZW'(7334);
      5'd10:   v = ZW'(3667);
      5'd11:   v = ZW'(1833);
      5'd12:   v = ZW'(917);
      5'd13:   v = ZW'(458);
      5'd14:   v = ZW'(229);
      5'd15:   v = ZW'(115);
      5'd16:   v = ZW'(57);
      5'd17:   v = ZW'(29);
      5'd18:   v = ZW'(14);
      5'd19:   v = ZW'(7);
      5'd20:   v = ZW'(4);
      5'd21:   v = ZW'(2);
      5'd22:   v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/magnetometer_heading.sv =====
// ---------------------------------------------------------------------------
// Magnetometer heading
// Calibrated, reoriented field and compass heading from one raw sample.
//
//   channel   direction  handshake                 payload
//   sample    in         in_valid_i / in_stall_o   raw_x_i, raw_y_i, raw_z_i
//   result    out        out_valid_o / out_stall_i field_x/y/z_o, azimuth_deg_o,
//                                                  bearing_sector_o
//   config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One sample per cycle while the result side is not stalled: two
// front stages, one rotation cell per arctangent step, four back stages.
// Each stage moves on when the next has room, so bubbles close up and a
// stalled result does not stop new samples entering free stages.
// Reset clears all stage valids and loads the register defaults (unit gains).
// ---------------------------------------------------------------------------
`include "magnetometer_heading_macros.svh"

module magnetometer_heading (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] raw_x_i,
  input  logic [15:0] raw_y_i,
  input  logic [15:0] raw_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] field_x_o,
  output logic [15:0] field_y_o,
  output logic [15:0] field_z_o,
  output logic [8:0]  azimuth_deg_o,
  output logic [3:0]  bearing_sector_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int N = mhead_pkg::ANGLE_STAGES;

  mhead_pkg::cfg_t    cfg_q;
  mhead_pkg::cordic_t chain_data [N+1];
  logic [N:0]         chain_valid;
  logic [N:0]         chain_ready;
  logic               front_ready;
  mhead_pkg::field_t  out_field;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_x <= '0;
      cfg_q.offset_y <= '0;
      cfg_q.offset_z <= '0;
      cfg_q.scale_x  <= 16'd16384;
      cfg_q.scale_y  <= 16'd16384;
      cfg_q.scale_z  <= 16'd16384;
      cfg_q.mount    <= '0;
      cfg_q.decl     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (mhead_pkg::cfg_idx_e'(cfg_index_i))
        mhead_pkg::CFG_OFFSET_X: cfg_q.offset_x <= cfg_data_i;
        mhead_pkg::CFG_OFFSET_Y: cfg_q.offset_y <= cfg_data_i;
        mhead_pkg::CFG_OFFSET_Z: cfg_q.offset_z <= cfg_data_i;
        mhead_pkg::CFG_SCALE_X:  cfg_q.scale_x  <= cfg_data_i;
        mhead_pkg::CFG_SCALE_Y:  cfg_q.scale_y  <= cfg_data_i;
        mhead_pkg::CFG_SCALE_Z:  cfg_q.scale_z  <= cfg_data_i;
        mhead_pkg::CFG_MOUNT:    cfg_q.mount    <= cfg_data_i[2:0];
        mhead_pkg::CFG_DECL:     cfg_q.decl     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mhead_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (front_ready),
    .raw_x_i     (raw_x_i),
    .raw_y_i     (raw_y_i),
    .raw_z_i     (raw_z_i),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .out_data_o  (chain_data[0])
  );

  assign in_stall_o = !front_ready;

  for (genvar g = 0; g < N; g++) begin : g_cell
    mhead_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .stage_i     (mhead_pkg::STAGE_W'(g)),
      .in_valid_i  (chain_valid[g]),
      .in_ready_o  (chain_ready[g]),
      .in_data_i   (chain_data[g]),
      .out_valid_o (chain_valid[g+1]),
      .out_ready_i (chain_ready[g+1]),
      .out_data_o  (chain_data[g+1])
    );
  end

  mhead_finish u_finish (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .decl_i       (cfg_q.decl),
    .in_valid_i   (chain_valid[N]),
    .in_ready_o   (chain_ready[N]),
    .in_data_i    (chain_data[N]),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (!out_stall_i),
    .out_field_o  (out_field),
    .out_deg_o    (azimuth_deg_o),
    .out_sector_o (bearing_sector_o)
  );

  assign field_x_o = out_field.fx;
  assign field_y_o = out_field.fy;
  assign field_z_o = out_field.fz;

  `MH_ASSERT(a_az_range, out_valid_o |-> (azimuth_deg_o < 9'd360), "azimuth out of range")
  `MH_ASSERT(a_flow_thru, !out_stall_i |-> !in_stall_o, "input stalled with output free")
  `MH_ASSERT(a_north_sector, (out_valid_o && azimuth_deg_o < 9'd12) |-> (bearing_sector_o == 4'd0), "north sector wrong")
  `MH_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> (!out_valid_o && !(|chain_valid)), "valid in reset")

endmodule

// ===== rtl/mhead_front.sv =====
// ---------------------------------------------------------------------------
// Magnetometer heading front end
// Offset, gain and saturation per axis, then mounting remap and the
// quadrant set-up of the rotation chain. Two register stages.
// ---------------------------------------------------------------------------
module mhead_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mhead_pkg::cfg_t   cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [15:0]       raw_x_i,
  input  logic [15:0]       raw_y_i,
  input  logic [15:0]       raw_z_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mhead_pkg::cordic_t out_data_o
);

  function automatic logic signed [15:0] correct_axis(input logic signed [15:0] raw,
                                                      input logic signed [15:0] off,
                                                      input logic [15:0]        scl);
    logic signed [16:0] d;
    logic signed [33:0] p;
    logic signed [19:0] s;
    logic signed [15:0] r;
    d = $signed({raw[15], raw}) - $signed({off[15], off});
    p = 34'(d) * 34'($signed({1'b0, scl}));
    s = $signed(p[33:14]);
    if (s > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (s < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = s[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] neg16(input logic signed [15:0] v);
    logic signed [15:0] r;
    r = (v == 16'sh8000) ? 16'sh7fff : -v;
    return r;
  endfunction

  logic               v1_q, v2_q;
  logic               ready1, ready2;
  mhead_pkg::field_t  ax_q;
  mhead_pkg::field_t  or_s;
  mhead_pkg::cordic_t init_s, data_q;

  assign ready2     = !v2_q || out_ready_i;
  assign ready1     = !v1_q || ready2;
  assign in_ready_o = ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= in_valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1 && in_valid_i) begin
      ax_q.fx <= correct_axis(raw_x_i, cfg_i.offset_x, cfg_i.scale_x);
      ax_q.fy <= correct_axis(raw_y_i, cfg_i.offset_y, cfg_i.scale_y);
      ax_q.fz <= correct_axis(raw_z_i, cfg_i.offset_z, cfg_i.scale_z);
    end
    if (ready2 && v1_q) begin
      data_q <= init_s;
    end
  end

  always_comb begin
    unique case (mhead_pkg::mount_e'(cfg_i.mount))
      mhead_pkg::MNT_ROT0: begin
        or_s = '{ax_q.fx, ax_q.fy, ax_q.fz};
      end
      mhead_pkg::MNT_ROT90: begin
        or_s = '{ax_q.fy, neg16(ax_q.fx), ax_q.fz};
      end
      mhead_pkg::MNT_ROT180: begin
        or_s = '{neg16(ax_q.fx), neg16(ax_q.fy), ax_q.fz};
      end
      mhead_pkg::MNT_ROT270: begin
        or_s = '{neg16(ax_q.fy), ax_q.fx, ax_q.fz};
      end
      mhead_pkg::MNT_FLIP_ROT0: begin
        or_s = '{neg16(ax_q.fx), ax_q.fy, neg16(ax_q.fz)};
      end
      mhead_pkg::MNT_FLIP_ROT90: begin
        or_s = '{ax_q.fy, ax_q.fx, neg16(ax_q.fz)};
      end
      mhead_pkg::MNT_FLIP_ROT180: begin
        or_s = '{ax_q.fx, neg16(ax_q.fy), neg16(ax_q.fz)};
      end
      default: begin
        or_s = '{neg16(ax_q.fy), neg16(ax_q.fx), neg16(ax_q.fz)};
      end
    endcase
  end

  // On an axis the angle is final at once; in the left half-plane flip the vector and start from +/-180 degrees
  always_comb begin
    init_s.f    = or_s;
    init_s.x    = mhead_pkg::XW'(or_s.fx);
    init_s.y    = mhead_pkg::XW'(or_s.fy);
    init_s.z    = '0;
    init_s.hold = 1'b0;
    if (or_s.fy == 16'sd0) begin
      init_s.hold = 1'b1;
      init_s.z    = (or_s.fx < 16'sd0) ? mhead_pkg::Z_DEG180 : '0;
    end else if (or_s.fx == 16'sd0) begin
      init_s.hold = 1'b1;
      init_s.z    = (or_s.fy > 16'sd0) ? mhead_pkg::Z_DEG90 : -mhead_pkg::Z_DEG90;
    end else if (or_s.fx < 16'sd0) begin
      init_s.z = (or_s.fy > 16'sd0) ? mhead_pkg::Z_DEG180 : -mhead_pkg::Z_DEG180;
      init_s.x = -mhead_pkg::XW'(or_s.fx);
      init_s.y = -mhead_pkg::XW'(or_s.fy);
    end
  end

  assign out_valid_o = v2_q;
  assign out_data_o  = data_q;

endmodule

// ===== rtl/mhead_cell.sv =====
// ---------------------------------------------------------------------------
// Magnetometer heading rotation cell
// One vectoring micro-rotation with its own register stage.
// ---------------------------------------------------------------------------
module mhead_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mhead_pkg::STAGE_W-1:0] stage_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mhead_pkg::cordic_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mhead_pkg::cordic_t            out_data_o
);

  logic                                valid_q;
  mhead_pkg::cordic_t                  data_q, nxt;
  logic signed [mhead_pkg::XW-1:0]     sx, sy;
  logic signed [mhead_pkg::ZW-1:0]     ang;

  assign in_ready_o = !valid_q || out_ready_i;

  assign sx  = in_data_i.x >>> stage_i;
  assign sy  = in_data_i.y >>> stage_i;
  assign ang = mhead_pkg::atan_entry(stage_i);

  always_comb begin
    nxt = in_data_i;
    if (!in_data_i.hold) begin
      if (in_data_i.y > 0) begin
        nxt.x = in_data_i.x + sy;
        nxt.y = in_data_i.y - sx;
        nxt.z = in_data_i.z + ang;
      end else begin
        nxt.x = in_data_i.x - sy;
        nxt.y = in_data_i.y + sx;
        nxt.z = in_data_i.z - ang;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= nxt;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== rtl/mhead_finish.sv =====
// ---------------------------------------------------------------------------
// Magnetometer heading back end
// Declination, truncation to whole degrees, wrap and sector rounding.
// Four register stages; the output registers sit in the last one.
// ---------------------------------------------------------------------------
module mhead_finish (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [15:0] decl_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mhead_pkg::cordic_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mhead_pkg::field_t  out_field_o,
  output logic [8:0]         out_deg_o,
  output logic [3:0]         out_sector_o
);

  localparam logic [16:0] RECIP_100 = 17'd83887;  // ceil(2^23 / 100)
  localparam logic [10:0] RECIP_90  = 11'd1457;   // ceil(2^17 / 90)

  logic [3:0]        valid_q;
  logic [4:0]        ready;

  mhead_pkg::field_t f1_q, f2_q, f3_q, f4_q;
  logic              neg1_q;
  logic [15:0]       n1_q;
  logic signed [10:0] deg2_q;
  logic [8:0]        deg3_q, deg4_q;
  logic [3:0]        sec4_q;

  logic signed [33:0] zt, tot, mag;
  logic [32:0]        quo_p;
  logic [9:0]         quo;
  logic signed [10:0] deg_s;
  logic [8:0]         wrap_s;
  logic [10:0]        sec_n;
  logic [21:0]        sec_p;
  logic [4:0]         sec_raw;
  logic [3:0]         sec_s;

  assign ready[4] = out_ready_i;
  for (genvar k = 0; k < 4; k++) begin : g_rdy
    assign ready[k] = !valid_q[k] || ready[k+1];
  end
  assign in_ready_o = ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) valid_q[0] <= in_valid_i;
      if (ready[1]) valid_q[1] <= valid_q[0];
      if (ready[2]) valid_q[2] <= valid_q[1];
      if (ready[3]) valid_q[3] <= valid_q[2];
    end
  end

  // angle * 100 + decl * 65536, in 1/6553600 degree
  always_comb begin
    zt  = 34'(in_data_i.z);
    tot = (zt <<< 6) + (zt <<< 5) + (zt <<< 2) + (34'(decl_i) <<< 16);
    mag = tot[33] ? -tot : tot;
  end

  // truncate toward zero: magnitude / 65536 / 100, sign restored
  always_comb begin
    quo_p = 33'(n1_q) * 33'(RECIP_100);
    quo   = quo_p[32:23];
    deg_s = neg1_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  always_comb begin
    if (deg2_q < -11'sd360) begin
      wrap_s = 9'(deg2_q + 11'sd720);
    end else if (deg2_q < 11'sd0) begin
      wrap_s = 9'(deg2_q + 11'sd360);
    end else if (deg2_q >= 11'sd720) begin
      wrap_s = 9'(deg2_q - 11'sd720);
    end else if (deg2_q >= 11'sd360) begin
      wrap_s = 9'(deg2_q - 11'sd360);
    end else begin
      wrap_s = 9'(deg2_q);
    end
  end

  // (4 * deg + 45) / 90, sixteen folds back to north
  always_comb begin
    sec_n   = {deg3_q, 2'b00} + 11'd45;
    sec_p   = 22'(sec_n) * 22'(RECIP_90);
    sec_raw = sec_p[21:17];
    sec_s   = (sec_raw == 5'd16) ? 4'd0 : sec_raw[3:0];
  end

  always_ff @(posedge clk_i) begin
    if (ready[0] && in_valid_i) begin
      f1_q   <= in_data_i.f;
      neg1_q <= tot[33];
      n1_q   <= mag[31:16];
    end
    if (ready[1] && valid_q[0]) begin
      f2_q   <= f1_q;
      deg2_q <= deg_s;
    end
    if (ready[2] && valid_q[1]) begin
      f3_q   <= f2_q;
      deg3_q <= wrap_s;
    end
    if (ready[3] && valid_q[2]) begin
      f4_q   <= f3_q;
      deg4_q <= deg3_q;
      sec4_q <= sec_s;
    end
  end

  assign out_valid_o  = valid_q[3];
  assign out_field_o  = f4_q;
  assign out_deg_o    = deg4_q;
  assign out_sector_o = sec4_q;

endmodule

// ===== test/heading_checker.sv =====
// ---------------------------------------------------------------------------
// Magnetometer heading checker
// Watches the sample, result and register channels of the heading block. Each
// accepted sample is run through a bit-exact heading predictor under the
// register values in force. Each accepted result is compared field by field
// with the oldest prediction. Mismatch count and outstanding predictions are
// passed to the top.
// ---------------------------------------------------------------------------
module heading_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [15:0] raw_x_i,
  input  logic [15:0] raw_y_i,
  input  logic [15:0] raw_z_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] field_x_i,
  input  logic [15:0] field_y_i,
  input  logic [15:0] field_z_i,
  input  logic [8:0]  azimuth_deg_i,
  input  logic [3:0]  bearing_sector_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          error_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint DEG_Q16     = 65536;
  localparam longint CENTIDEG_Q16 = 6553600;  // one degree, angle*100 scale

  typedef struct packed {
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic signed [15:0] fz;
    logic [8:0]         azimuth;
    logic [3:0]         sector;
  } heading_t;

  mhead_pkg::cfg_t settings;
  heading_t        heading_q[$];
  heading_t        want;

  function automatic longint arctan_q16(int i);
    case (i)
      0:       return 2949120;
      1:       return 1740967;
      2:       return 919879;
      3:       return 466945;
      4:       return 234379;
      5:       return 117304;
      6:       return 58666;
      7:       return 29335;
      8:       return 14668;
      9:       return 7334;
      10:      return 3667;
      11:      return 1833;
      12:      return 917;
      13:      return 458;
      14:      return 229;
      15:      return 115;
      16:      return 57;
      17:      return 29;
      18:      return 14;
      19:      return 7;
      20:      return 4;
      21:      return 2;
      22:      return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint negate16(longint v);
    return clamp16(-v);
  endfunction

  function automatic longint calibrate(logic signed [15:0] raw, logic signed [15:0] off,
                                       logic [15:0] gain);
    longint diff;
    diff = longint'(raw) - longint'(off);
    return clamp16((diff * longint'(gain)) >>> 14);
  endfunction

  // atan2(y, x) in degrees, 16 fraction bits, vectoring rotations
  function automatic longint heading_q16(longint x, longint y);
    longint z;
    longint nx;
    longint ny;
    z = 0;
    if (y == 0) return (x < 0) ? 180 * DEG_Q16 : 0;
    if (x == 0) return (y > 0) ? 90 * DEG_Q16 : -90 * DEG_Q16;
    if (x < 0) begin
      z = (y > 0) ? 180 * DEG_Q16 : -180 * DEG_Q16;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < mhead_pkg::ANGLE_STAGES && i < 24; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + arctan_q16(i);
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - arctan_q16(i);
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic heading_t predict_heading(mhead_pkg::cfg_t c, logic signed [15:0] rx,
                                               logic signed [15:0] ry,
                                               logic signed [15:0] rz);
    longint   x, y, z;
    longint   fx, fy, fz;
    longint   total, deg, sector;
    heading_t h;
    x = calibrate(rx, c.offset_x, c.scale_x);
    y = calibrate(ry, c.offset_y, c.scale_y);
    z = calibrate(rz, c.offset_z, c.scale_z);
    case (mhead_pkg::mount_e'(c.mount))
      mhead_pkg::MNT_ROT0: begin
        fx = x;           fy = y;           fz = z;
      end
      mhead_pkg::MNT_ROT90: begin
        fx = y;           fy = negate16(x); fz = z;
      end
      mhead_pkg::MNT_ROT180: begin
        fx = negate16(x); fy = negate16(y); fz = z;
      end
      mhead_pkg::MNT_ROT270: begin
        fx = negate16(y); fy = x;           fz = z;
      end
      mhead_pkg::MNT_FLIP_ROT0: begin
        fx = negate16(x); fy = y;           fz = negate16(z);
      end
      mhead_pkg::MNT_FLIP_ROT90: begin
        fx = y;           fy = x;           fz = negate16(z);
      end
      mhead_pkg::MNT_FLIP_ROT180: begin
        fx = x;           fy = negate16(y); fz = negate16(z);
      end
      default: begin
        fx = negate16(y); fy = negate16(x); fz = negate16(z);
      end
    endcase
    // declination folded in exactly, then truncated toward zero
    total = heading_q16(fx, fy) * 100 + longint'($signed(c.decl)) * DEG_Q16;
    deg   = total / CENTIDEG_Q16;
    while (deg < 0) deg = deg + 360;
    while (deg >= 360) deg = deg - 360;
    sector = (4 * deg + 45) / 90;
    if (sector >= 16) sector = 0;
    h.fx      = 16'(fx);
    h.fy      = 16'(fy);
    h.fz      = 16'(fz);
    h.azimuth = 9'(deg);
    h.sector  = 4'(sector);
    return h;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count_o++;
  endtask

  task automatic check_field(string name, longint got, longint expected);
    if (got != expected)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, expected));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings         = '0;
      settings.scale_x = 16'd16384;
      settings.scale_y = 16'd16384;
      settings.scale_z = 16'd16384;
      settings.mount   = mhead_pkg::MNT_ROT0;
      heading_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (heading_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result azimuth %0d", azimuth_deg_i));
        end else begin
          want = heading_q.pop_front();
          check_field("field_x", $signed(field_x_i), want.fx);
          check_field("field_y", $signed(field_y_i), want.fy);
          check_field("field_z", $signed(field_z_i), want.fz);
          check_field("azimuth_deg", azimuth_deg_i, want.azimuth);
          check_field("bearing_sector", bearing_sector_i, want.sector);
        end
      end
      if (in_valid_i && !in_stall_i)
        heading_q.push_back(predict_heading(settings, raw_x_i, raw_y_i, raw_z_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (mhead_pkg::cfg_idx_e'(cfg_index_i))
          mhead_pkg::CFG_OFFSET_X: settings.offset_x = cfg_data_i;
          mhead_pkg::CFG_OFFSET_Y: settings.offset_y = cfg_data_i;
          mhead_pkg::CFG_OFFSET_Z: settings.offset_z = cfg_data_i;
          mhead_pkg::CFG_SCALE_X:  settings.scale_x  = cfg_data_i;
          mhead_pkg::CFG_SCALE_Y:  settings.scale_y  = cfg_data_i;
          mhead_pkg::CFG_SCALE_Z:  settings.scale_z  = cfg_data_i;
          mhead_pkg::CFG_MOUNT:    settings.mount    = cfg_data_i[2:0];
          mhead_pkg::CFG_DECL:     settings.decl     = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = heading_q.size();
  end

endmodule

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// Magnetometer heading testbench
// Drives directed and random samples through the heading block across a range
// of calibration, mounting and declination settings, with random idling on
// the sample side and random stalls on the result side. The checker beside
// the block predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SEGMENTS      = 10;
  localparam int SEG_ITEMS     = 133;
  localparam int SETTLE_CYCLES = 30;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] raw_x, raw_y, raw_z;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] field_x, field_y, field_z;
  logic [8:0]  azimuth_deg;
  logic [3:0]  bearing_sector;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int          errors;
  int          pending;
  int          idle_pct;
  int          stall_pct;
  int          quiet = 0;

  // sample-side view of the programmed registers, used to aim the stimulus
  logic [15:0] off_v [3];
  logic [15:0] gain_v [3];
  logic [2:0]  mount_v;
  logic [15:0] decl_v;

  magnetometer_heading dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .raw_x_i         (raw_x),
    .raw_y_i         (raw_y),
    .raw_z_i         (raw_z),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .field_x_o       (field_x),
    .field_y_o       (field_y),
    .field_z_o       (field_z),
    .azimuth_deg_o   (azimuth_deg),
    .bearing_sector_o(bearing_sector),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  heading_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .raw_x_i         (raw_x),
    .raw_y_i         (raw_y),
    .raw_z_i         (raw_z),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .field_x_i       (field_x),
    .field_y_i       (field_y),
    .field_z_i       (field_z),
    .azimuth_deg_i   (azimuth_deg),
    .bearing_sector_i(bearing_sector),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .error_count_o   (errors),
    .pending_o       (pending)
  );

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_x    <= x;
    raw_y    <= y;
    raw_z    <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // leaves valid high; the caller drops it after the last write
  task automatic write_reg(mhead_pkg::cfg_idx_e idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic program_settings(int seg);
    int dcl;
    for (int i = 0; i < 3; i++) begin
      case (seg)
        0: begin
          off_v[i] = 16'h0000; gain_v[i] = 16'd16384;
        end
        1: begin
          off_v[i] = 16'h0000; gain_v[i] = 16'hFFFF;
        end
        2: begin
          off_v[i] = 16'h8000; gain_v[i] = 16'd16384;
        end
        3: begin
          off_v[i] = 16'h7FFF; gain_v[i] = 16'h0000;
        end
        4: begin
          dcl       = int'($urandom_range(0, 4000)) - 2000;
          off_v[i]  = dcl[15:0];
          gain_v[i] = 16'($urandom_range(8192, 32768));
        end
        default: begin
          off_v[i]  = 16'($urandom);
          gain_v[i] = 16'($urandom);
        end
      endcase
    end
    case (seg)
      0:       dcl = 0;
      1:       dcl = 17999;
      2:       dcl = -17999;
      3:       dcl = 32767;   // past a half turn, wraps
      4:       dcl = -32768;
      default: dcl = $urandom_range(0, 1) ? int'($urandom_range(0, 65535)) - 32768
                                          : int'($urandom_range(0, 35998)) - 17999;
    endcase
    decl_v  = dcl[15:0];
    mount_v = (seg < 8) ? 3'(seg) : 3'($urandom_range(0, 7));
    write_reg(mhead_pkg::CFG_OFFSET_X, off_v[0]);
    write_reg(mhead_pkg::CFG_OFFSET_Y, off_v[1]);
    write_reg(mhead_pkg::CFG_OFFSET_Z, off_v[2]);
    write_reg(mhead_pkg::CFG_SCALE_X, gain_v[0]);
    write_reg(mhead_pkg::CFG_SCALE_Y, gain_v[1]);
    write_reg(mhead_pkg::CFG_SCALE_Z, gain_v[2]);
    write_reg(mhead_pkg::CFG_MOUNT, {13'b0, mount_v});
    write_reg(mhead_pkg::CFG_DECL, decl_v);
    cfg_valid <= 1'b0;
  endtask

  // mostly near the hard-iron centre so headings spread round the circle
  function automatic logic [15:0] pick_axis(logic [15:0] off);
    int r;
    int d;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      d = int'($urandom_range(0, 8000)) - 4000;
      return off + d[15:0];
    end
    if (r < 65) return 16'($urandom);
    if (r < 75) return off;
    if (r < 85) return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
    d = $urandom_range(1, 3);
    if ($urandom_range(0, 1)) d = -d;
    return off + d[15:0];
  endfunction

  initial begin
    rst_n     = 1'b1;
    in_valid  = 1'b0;
    raw_x     = '0;
    raw_y     = '0;
    raw_z     = '0;
    cfg_valid = 1'b0;
    cfg_index = mhead_pkg::CFG_OFFSET_X;
    cfg_data  = '0;
    idle_pct  = 0;
    stall_pct = 0;
    // reset edge ahead of the first clock so the valids are clear from the start
    #1ns rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: unit gains, no offsets, no rotation, no declination
    send(16'sd0, 16'sd0, 16'sd0);
    send(16'sd100, 16'sd0, 16'sd7);
    send(-16'sd100, 16'sd0, -16'sd7);
    send(16'sd0, 16'sd100, 16'sd1);
    send(16'sd0, -16'sd100, 16'sd1);
    send(-16'sd100, 16'sd100, 16'sd0);
    send(-16'sd100, -16'sd100, 16'sd0);
    send(16'sd32767, 16'sd32767, 16'sd32767);
    send(-16'sd32768, -16'sd32768, -16'sd32768);
    send(-16'sd32768, 16'sd0, 16'sd0);
    send(16'sd0, -16'sd32768, 16'sd0);
    send(16'sd1, 16'sd1, 16'sd1);
    send(16'sd100, -16'sd5, 16'sd0);
    send(-16'sd100, -16'sd1, 16'sd0);
    send(-16'sd100, 16'sd1, 16'sd0);
    send(16'sd1000, 16'sd414, 16'sd0);
    send(16'sd1000, 16'sd415, 16'sd0);
    send(16'sd1000, -16'sd1000, 16'sd0);
    send(16'sd1000, -16'sd90, 16'sd0);   // sector rounds up to north
    send(-16'sd1, -16'sd1, 16'sd0);
    send(16'sd32767, -16'sd32768, 16'sd0);
    send(16'sd12345, -16'sd23456, 16'sd32767);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_for_results();
      program_settings(seg);
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      for (int n = 0; n < SEG_ITEMS; n++) begin
        send(pick_axis(off_v[0]), pick_axis(off_v[1]), pick_axis(off_v[2]));
        if (seg == 5 && n == SEG_ITEMS / 2) wait_for_results();
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mhead_pkg.sv
rtl/mhead_front.sv
rtl/mhead_cell.sv
rtl/mhead_finish.sv
rtl/magnetometer_heading.sv
test/heading_checker.sv
test/testbench.sv
